FILE: rtl/bracket_sequence_unrank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket sequence unranker
// Concurrent checks clocked on clk and held off during rst; empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BRACKET_SEQUENCE_UNRANK_ASSERT_SVH
`define BRACKET_SEQUENCE_UNRANK_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSU_ASSERT_IMP(lbl, ante, cons, msg)
`define BSU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/bsu_pkg.sv
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared widths, defaults and symbol codes of the bracket sequence unranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsu_pkg;

  localparam int RANK_W        = 63;
  localparam int SYM_W         = 2;
  localparam int PC_W          = 5;
  localparam int MAX_PAIRS_DEF = 16;

  localparam logic [PC_W-1:0] PAIR_COUNT_RST = PC_W'(1);

  typedef enum logic [SYM_W-1:0] {
    SYM_OPEN_RND  = 2'd0,
    SYM_CLOSE_RND = 2'd1,
    SYM_OPEN_SQ   = 2'd2,
    SYM_CLOSE_SQ  = 2'd3
  } symbol_t;

endpackage

FILE: rtl/bsu_rank_if.sv
// ----------------------------------------------------------------------------
// bsu_rank_if
// Valid/ready channel carrying one rank per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsu_rank_if;
  import bsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);

endinterface

FILE: rtl/bsu_sym_if.sv
// ----------------------------------------------------------------------------
// bsu_sym_if
// Valid/ready channel carrying one bracket symbol per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsu_sym_if;
  import bsu_pkg::*;

  logic    valid;
  logic    ready;
  symbol_t symbol;
  logic    last;
  logic    rank_error;

  modport source (output valid, output symbol, output last, output rank_error, input ready);
  modport sink   (input valid, input symbol, input last, input rank_error, output ready);

endinterface

FILE: rtl/bracket_sequence_unrank.sv
// ----------------------------------------------------------------------------
// bracket_sequence_unrank
// Turns a rank into the balanced two-kind bracket sequence of that rank.
// ----------------------------------------------------------------------------
// After reset the block builds its ballot-count table of
// (2*MAX_PAIRS+1)*(MAX_PAIRS+1) entries, each read in BUILD_RD and written
// in BUILD_WR, with ranks.ready low meanwhile; pair_count writes are taken
// at any time and do not rebuild the table. Each rank then goes through the
// total-count check (TOTAL_RD, TOTAL_CMP), then per symbol one table read
// (SYM_RD) and one to three passes through the single shifter and 63-bit
// compare/subtract unit (CMP_OPEN, CMP_CLOSE, CMP_SQUARE); a symbol waits
// while syms holds a beat not yet taken. An out-of-range rank returns one
// beat with rank_error and last set. ranks.ready is high only between items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_sequence_unrank #(
  parameter int MAX_PAIRS = bsu_pkg::MAX_PAIRS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [bsu_pkg::PC_W-1:0] cfg_wdata,
  bsu_rank_if.sink                ranks,
  bsu_sym_if.source               syms
);
  import bsu_pkg::*;

  `include "bracket_sequence_unrank_assert.svh"

  localparam int ROWS   = 2 * MAX_PAIRS + 1;
  localparam int COLS   = MAX_PAIRS + 1;
  localparam int R_W    = $clog2(ROWS);
  localparam int H_W    = $clog2(COLS);
  localparam int SK_W   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W  = 2 * MAX_PAIRS;
  localparam int COMP_W = 3 * MAX_PAIRS;

  localparam logic KIND_RND = 1'b0;
  localparam logic KIND_SQ  = 1'b1;

  typedef enum logic [3:0] {
    BUILD_RD,
    BUILD_WR,
    IDLE,
    TOTAL_RD,
    TOTAL_CMP,
    SYM_RD,
    CMP_OPEN,
    CMP_CLOSE,
    CMP_SQUARE
  } state_t;

  state_t            state;
  logic [PC_W-1:0]   pair_count;
  logic [R_W-1:0]    br;
  logic [H_W-1:0]    bh;
  logic [RANK_W-1:0] rank_left;
  logic [H_W-1:0]    depth;
  logic [R_W-1:0]    pos;
  logic [H_W-1:0]    sh;
  logic              out_vld;
  symbol_t           out_sym;
  logic              out_last;
  logic              out_err;

  logic [CNT_W-1:0]  count_mem [ROWS][COLS];
  logic              kind_stack [MAX_PAIRS];
  logic [CNT_W-1:0]  ta;
  logic [CNT_W-1:0]  tb;
  logic              ta_ok;
  logic              tb_ok;

  logic [H_W-1:0]    np;
  logic [R_W-1:0]    len_m1;
  logic [R_W-1:0]    r_left;
  logic [R_W-1:0]    r_gap;
  logic [R_W-1:0]    brm1;
  logic [H_W-1:0]    dm1;
  logic              top_kind;
  logic              out_free;

  logic              rd_en;
  logic [R_W-1:0]    ra_r;
  logic [H_W-1:0]    ra_h;
  logic              ra_ok;
  logic [R_W-1:0]    rb_r;
  logic [H_W-1:0]    rb_h;
  logic              rb_ok;
  logic              mem_we;
  logic [CNT_W-1:0]  mem_wdata;

  logic [CNT_W-1:0]  ta_v;
  logic [CNT_W-1:0]  tb_v;
  logic [CNT_W-1:0]  sel_t;
  logic [H_W-1:0]    sel_sh;
  logic [COMP_W-1:0] op_sh;
  logic [RANK_W-1:0] op_ext;
  logic              lt;
  logic [RANK_W-1:0] diff;

  logic              emit;
  symbol_t           emit_sym;
  logic              emit_err;
  logic              emit_last;
  logic              emit_open;

  assign np = (pair_count == '0) ? H_W'(1) :
              (pair_count > PC_W'(MAX_PAIRS)) ? H_W'(MAX_PAIRS) : H_W'(pair_count);
  assign len_m1   = R_W'({np, 1'b0}) - R_W'(1);
  assign r_left   = len_m1 - pos;
  assign r_gap    = r_left - R_W'(depth) - R_W'(1);
  assign brm1     = br - R_W'(1);
  assign dm1      = depth - H_W'(1);
  assign top_kind = kind_stack[dm1[SK_W-1:0]];
  assign out_free = !out_vld || syms.ready;

  assign ranks.ready     = (state == IDLE);
  assign syms.valid      = out_vld;
  assign syms.symbol     = out_sym;
  assign syms.last       = out_last;
  assign syms.rank_error = out_err;

  // table read addresses
  always_comb begin
    rd_en = 1'b0;
    ra_r  = '0;
    ra_h  = '0;
    ra_ok = 1'b0;
    rb_r  = '0;
    rb_h  = '0;
    rb_ok = 1'b0;
    unique case (state)
      BUILD_RD: begin
        rd_en = 1'b1;
        ra_r  = brm1;
        ra_h  = bh + H_W'(1);
        ra_ok = (br != '0) && (bh != H_W'(MAX_PAIRS));
        rb_r  = brm1;
        rb_h  = bh - H_W'(1);
        rb_ok = (br != '0) && (bh != '0);
      end
      TOTAL_RD: begin
        rd_en = 1'b1;
        ra_r  = len_m1 + R_W'(1);
        ra_ok = 1'b1;
      end
      SYM_RD: begin
        rd_en = 1'b1;
        ra_r  = r_left;
        ra_h  = depth + H_W'(1);
        ra_ok = (depth < np);
        rb_r  = r_left;
        rb_h  = dm1;
        rb_ok = (depth != '0) && (top_kind == KIND_RND);
      end
      default: begin
      end
    endcase
  end

  assign ta_v      = ta_ok ? ta : '0;
  assign tb_v      = tb_ok ? tb : '0;
  assign mem_we    = (state == BUILD_WR);
  assign mem_wdata = (br == '0) ? CNT_W'(bh == '0) : ta_v + tb_v;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[br][bh] <= mem_wdata;
    end
    if (rd_en) begin
      ta    <= count_mem[ra_r][ra_h];
      tb    <= count_mem[rb_r][rb_h];
      ta_ok <= ra_ok;
      tb_ok <= rb_ok;
    end
  end

  // shared shift / compare / subtract unit
  always_comb begin
    unique case (state)
      TOTAL_CMP: begin
        sel_t  = ta_v;
        sel_sh = np;
      end
      CMP_CLOSE: begin
        sel_t  = tb_v;
        sel_sh = sh + H_W'(1);
      end
      default: begin
        sel_t  = ta_v;
        sel_sh = sh;
      end
    endcase
  end

  assign op_sh  = COMP_W'(sel_t) << sel_sh;
  assign op_ext = RANK_W'(op_sh);
  assign lt     = rank_left < op_ext;
  assign diff   = rank_left - op_ext;

  // symbol decision
  always_comb begin
    emit     = 1'b0;
    emit_sym = SYM_OPEN_RND;
    emit_err = 1'b0;
    unique case (state)
      TOTAL_CMP: begin
        emit     = !lt && out_free;
        emit_err = 1'b1;
      end
      CMP_OPEN: begin
        emit = lt && out_free;
      end
      CMP_CLOSE: begin
        emit     = lt && out_free;
        emit_sym = SYM_CLOSE_RND;
      end
      CMP_SQUARE: begin
        emit     = out_free;
        emit_sym = lt ? SYM_OPEN_SQ : SYM_CLOSE_SQ;
      end
      default: begin
      end
    endcase
  end

  assign emit_last = emit_err || (r_left == '0);
  assign emit_open = (emit_sym == SYM_OPEN_RND) || (emit_sym == SYM_OPEN_SQ);

  always_ff @(posedge clk) begin
    if (emit && !emit_err && emit_open && (depth < H_W'(MAX_PAIRS))) begin
      kind_stack[depth[SK_W-1:0]] <= (emit_sym == SYM_OPEN_SQ) ? KIND_SQ : KIND_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BUILD_RD;
      pair_count <= PAIR_COUNT_RST;
      br         <= '0;
      bh         <= '0;
      rank_left  <= '0;
      depth      <= '0;
      pos        <= '0;
      out_vld    <= 1'b0;
    end else begin
      if (cfg_we) begin
        pair_count <= cfg_wdata;
      end

      if (emit) begin
        out_vld <= 1'b1;
      end else if (syms.ready) begin
        out_vld <= 1'b0;
      end

      unique case (state)
        BUILD_RD: begin
          state <= BUILD_WR;
        end
        BUILD_WR: begin
          state <= BUILD_RD;
          if (bh == H_W'(MAX_PAIRS)) begin
            bh <= '0;
            if (br == R_W'(ROWS - 1)) begin
              state <= IDLE;
            end else begin
              br <= br + R_W'(1);
            end
          end else begin
            bh <= bh + H_W'(1);
          end
        end
        IDLE: begin
          if (ranks.valid) begin
            rank_left <= ranks.rank;
            depth     <= '0;
            pos       <= '0;
            state     <= TOTAL_RD;
          end
        end
        TOTAL_RD: begin
          state <= TOTAL_CMP;
        end
        TOTAL_CMP: begin
          if (lt) begin
            state <= SYM_RD;
          end
        end
        SYM_RD: begin
          sh    <= H_W'(r_gap >> 1);
          state <= CMP_OPEN;
        end
        CMP_OPEN: begin
          if (!lt) begin
            rank_left <= diff;
            state     <= CMP_CLOSE;
          end
        end
        CMP_CLOSE: begin
          if (!lt) begin
            rank_left <= diff;
            state     <= CMP_SQUARE;
          end
        end
        CMP_SQUARE: begin
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (emit) begin
        out_sym  <= emit_sym;
        out_last <= emit_last;
        out_err  <= emit_err;
        state    <= emit_last ? IDLE : SYM_RD;
        if (!emit_err) begin
          pos <= pos + R_W'(1);
          if (emit_sym == SYM_CLOSE_SQ) begin
            rank_left <= diff;
          end
          if (emit_open) begin
            if (depth < H_W'(MAX_PAIRS)) begin
              depth <= depth + H_W'(1);
            end
          end else if (depth != '0) begin
            depth <= dm1;
          end
        end
      end
    end
  end

  `BSU_ASSERT_IMP(a_depth_bound, 1'b1, depth <= np, "open depth above pair count")
  `BSU_ASSERT_IMP(a_last_closes, emit && emit_last && !emit_err,
                  depth == H_W'(1) && (emit_sym == SYM_CLOSE_RND || emit_sym == SYM_CLOSE_SQ),
                  "final symbol is not a close at depth one")
  `BSU_ASSERT_NXT(a_err_idle, emit && emit_err, state == IDLE && depth == '0,
                  "rank error beat did not end the item")

endmodule
